FILE: hdl/sstwd_pkg.sv
`default_nettype none
package sstwd_pkg;

  localparam int DIGIT_COUNT_DEFAULT = 4;

  // Bus symbol kinds.
  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_BIT   = 2'd1;
  localparam logic [1:0] SYM_ACK   = 2'd2;
  localparam logic [1:0] SYM_STOP  = 2'd3;

  // Command codes.
  localparam logic CMD_SHOW   = 1'b0;
  localparam logic CMD_BRIGHT = 1'b1;

  localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
  localparam logic [7:0] BYTE_ADDR     = 8'hC0;
  localparam logic [7:0] BYTE_CTRL     = 8'h87;
  localparam logic [7:0] SEG_DP        = 8'h80;
  localparam logic [3:0] BRIGHT_MAX    = 4'd8;
  localparam logic [3:0] BRIGHT_RESET  = 4'd8;

  // Reciprocal of ten: (v * DIV10_MUL) >> DIV10_SHIFT equals v / 10 for v below 43690.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0: c = 8'h3f;
      4'd1: c = 8'h06;
      4'd2: c = 8'h5b;
      4'd3: c = 8'h4f;
      4'd4: c = 8'h66;
      4'd5: c = 8'h6d;
      4'd6: c = 8'h7d;
      4'd7: c = 8'h07;
      4'd8: c = 8'h7f;
      4'd9: c = 8'h6f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sstwd_front.sv
`default_nettype none
module sstwd_front #(
  parameter int DIGIT_COUNT = sstwd_pkg::DIGIT_COUNT_DEFAULT,
  parameter int QW = 1 + 8 + 8 * DIGIT_COUNT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          command,
  input  wire logic [13:0]   value,
  input  wire logic          separator,
  input  wire logic [3:0]    brightness,
  output logic               push_valid,
  input  wire logic          push_ready,
  output logic [QW-1:0]      push_data
);

  localparam int CW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_t;

  fstate_t                  state;
  logic                     cmd;
  logic                     sep;
  logic [13:0]              v;
  logic [CW-1:0]            step;
  logic [8*DIGIT_COUNT-1:0] segs;

  logic [29:0]   prod;
  logic [13:0]   quo;
  logic [13:0]   quo_x10;
  logic [3:0]    rem;
  logic [7:0]    code;
  logic [CW-1:0] slot;
  logic [3:0]    bsat;
  logic [7:0]    ctrl_byte;

  always_comb begin
    prod    = 30'(v) * 30'(sstwd_pkg::DIV10_MUL);
    quo     = 14'(prod >> sstwd_pkg::DIV10_SHIFT);
    quo_x10 = 14'((quo << 3) + (quo << 1));
    rem     = 4'(v - quo_x10);
    code    = sstwd_pkg::seg_code(rem);
    if ((DIGIT_COUNT >= 3) && (step == CW'(2)) && sep) begin
      code = code | sstwd_pkg::SEG_DP;
    end
    // Digits come out least significant first; the queue stores them most significant first.
    slot      = CW'(DIGIT_COUNT - 1) - step;
    bsat      = (brightness > sstwd_pkg::BRIGHT_MAX) ? sstwd_pkg::BRIGHT_MAX : brightness;
    ctrl_byte = sstwd_pkg::BYTE_CTRL + {4'd0, bsat};
  end

  assign busy       = (state != F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_data  = {cmd, ctrl_byte, segs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            cmd  <= command;
            sep  <= separator;
            v    <= value;
            step <= '0;
            state <= (command == sstwd_pkg::CMD_BRIGHT) ? F_PUSH : F_CONV;
          end
        end
        F_CONV: begin
          segs[8*slot +: 8] <= code;
          v    <= quo;
          step <= step + CW'(1);
          if (step == CW'(DIGIT_COUNT - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sstwd_fifo.sv
`default_nettype none
module sstwd_fifo #(
  parameter int QW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [QW-1:0] push_data,
  output logic               head_valid,
  output logic [QW-1:0]      head_data,
  input  wire logic          pop
);

  logic [QW-1:0] mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: hdl/sstwd_back.sv
`default_nettype none
module sstwd_back #(
  parameter int DIGIT_COUNT = sstwd_pkg::DIGIT_COUNT_DEFAULT,
  parameter int QW = 1 + 8 + 8 * DIGIT_COUNT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire logic [QW-1:0] head_data,
  output logic               pop,
  output logic               strobe,
  output logic [1:0]         symbol,
  output logic               bit_value,
  output logic               last
);

  localparam int BW = $clog2(DIGIT_COUNT + 1);

  typedef enum logic [1:0] {B_START, B_BIT, B_ACK, B_STOP} bstate_t;

  bstate_t       state;
  logic          frame;
  logic [BW-1:0] byte_idx;
  logic [2:0]    bit_idx;

  logic                     h_cmd;
  logic [7:0]               h_ctrl;
  logic [8*DIGIT_COUNT-1:0] h_segs;
  logic [BW-1:0]            dig_idx;
  logic [7:0]               cur_byte;
  logic                     last_byte;
  logic                     final_frame;

  always_comb begin
    {h_cmd, h_ctrl, h_segs} = head_data;
    dig_idx = byte_idx - BW'(1);
    if (h_cmd == sstwd_pkg::CMD_BRIGHT) begin
      cur_byte = h_ctrl;
    end else if (!frame) begin
      cur_byte = sstwd_pkg::BYTE_DATA_CMD;
    end else if (byte_idx == '0) begin
      cur_byte = sstwd_pkg::BYTE_ADDR;
    end else begin
      cur_byte = h_segs[8*dig_idx +: 8];
    end
    last_byte   = (h_cmd == sstwd_pkg::CMD_BRIGHT) || !frame ||
                  (byte_idx == BW'(DIGIT_COUNT));
    final_frame = (h_cmd == sstwd_pkg::CMD_BRIGHT) || frame;
    pop         = head_valid && (state == B_STOP) && final_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_START;
      frame     <= 1'b0;
      byte_idx  <= '0;
      bit_idx   <= '0;
      strobe    <= 1'b0;
      bit_value <= 1'b0;
      last      <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      bit_value <= 1'b0;
      last      <= 1'b0;
      if (head_valid) begin
        strobe <= 1'b1;
        case (state)
          B_START: begin
            symbol  <= sstwd_pkg::SYM_START;
            bit_idx <= '0;
            state   <= B_BIT;
          end
          B_BIT: begin
            symbol    <= sstwd_pkg::SYM_BIT;
            bit_value <= cur_byte[bit_idx];
            bit_idx   <= bit_idx + 3'd1;
            if (bit_idx == 3'd7) begin
              state <= B_ACK;
            end
          end
          B_ACK: begin
            symbol <= sstwd_pkg::SYM_ACK;
            if (last_byte) begin
              state <= B_STOP;
            end else begin
              byte_idx <= byte_idx + BW'(1);
              state    <= B_BIT;
            end
          end
          B_STOP: begin
            symbol   <= sstwd_pkg::SYM_STOP;
            last     <= final_frame;
            frame    <= !final_frame;
            byte_idx <= '0;
            state    <= B_START;
          end
          default: state <= B_START;
        endcase
      end
    end
  end

  a_last_is_stop: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> symbol == sstwd_pkg::SYM_STOP)
    else $error("last flagged on a symbol other than stop");
  a_bit_only_data: assert property (@(posedge clk) disable iff (rst)
    strobe && bit_value |-> symbol == sstwd_pkg::SYM_BIT)
    else $error("data level high outside a data bit");
  a_pop_gives_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> strobe && last)
    else $error("command retired without a final stop");

endmodule
`default_nettype wire

FILE: hdl/seven_segment_two_wire_display_sequencer.sv
`default_nettype none
// Two-wire seven-segment display sequencer. A command is taken when start is high and busy is
// low; strobe marks each bus symbol for exactly one cycle and the receiver cannot stall, so
// every strobed beat must be taken. The back end emits one symbol per clock while the queue
// holds a command; a display command goes out as two frames (data command byte, then address
// byte and DIGIT_COUNT segment bytes) and a brightness command as one frame (control byte).
// The front end converts one digit per cycle; a two-entry queue lets it take the next command
// while earlier symbols still go out, so the sustained rate is set by the symbol sequencer.
// The brightness register is written through cfg_valid/cfg_ready (always ready) and should
// only be changed while no command is pending.
module seven_segment_two_wire_display_sequencer #(
  parameter int DIGIT_COUNT = sstwd_pkg::DIGIT_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [13:0] value,
  input  wire logic        separator,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  output logic             strobe,
  output logic [1:0]       symbol,
  output logic             bit_value,
  output logic             last
);

  localparam int QW = 1 + 8 + 8 * DIGIT_COUNT;

  logic [3:0]    brightness;
  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          head_valid;
  logic [QW-1:0] head_data;
  logic          pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= sstwd_pkg::BRIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      brightness <= cfg_data;
    end
  end

  sstwd_front #(.DIGIT_COUNT(DIGIT_COUNT), .QW(QW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .value      (value),
    .separator  (separator),
    .brightness (brightness),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sstwd_fifo #(.QW(QW)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  sstwd_back #(.DIGIT_COUNT(DIGIT_COUNT), .QW(QW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .strobe     (strobe),
    .symbol     (symbol),
    .bit_value  (bit_value),
    .last       (last)
  );

endmodule
`default_nettype wire

FILE: verif/seven_segment_two_wire_display_sequencer_tb.sv
`timescale 1ns / 1ps
module seven_segment_two_wire_display_sequencer_tb;

  localparam int DIGITS = sstwd_pkg::DIGIT_COUNT_DEFAULT;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 100;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 40;

  localparam logic [7:0] SEGMENTS [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        cmd;
    logic [13:0] val;
    logic        sep;
    logic [3:0]  level;
    bit          known;
    logic [31:0] codes;
  } stim_row_t;

  typedef struct packed {
    logic [1:0] sym;
    logic       bit_value;
    logic       last;
  } bus_symbol_t;

  // Typed codes: a brightness row holds the control byte in the low byte, a display row
  // holds the four segment codes with the most significant digit in the top byte.
  localparam int DIRECTED_ROWS = 23;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_CMD, sstwd_pkg::CMD_BRIGHT, 14'd0,     1'b0, 4'd0,  1'b1, 32'h0000008f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd0,     1'b0, 4'd0,  1'b1, 32'h3f3f3f3f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd9999,  1'b0, 4'd0,  1'b1, 32'h6f6f6f6f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd9999,  1'b1, 4'd0,  1'b1, 32'h6fef6f6f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd16383, 1'b1, 4'd0,  1'b1, 32'h7dcf7f4f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd10000, 1'b0, 4'd0,  1'b1, 32'h3f3f3f3f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd1234,  1'b0, 4'd0,  1'b1, 32'h065b4f66},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd5678,  1'b1, 4'd0,  1'b1, 32'h6dfd077f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd0,     1'b1, 4'd0,  1'b1, 32'h3fbf3f3f},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd10922, 1'b0, 4'd0,  1'b0, 32'h0},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd5461,  1'b1, 4'd0,  1'b0, 32'h0},
    '{ROW_CFG, sstwd_pkg::CMD_SHOW,   14'd0,     1'b0, 4'd0,  1'b0, 32'h0},
    '{ROW_CMD, sstwd_pkg::CMD_BRIGHT, 14'd16383, 1'b1, 4'd0,  1'b1, 32'h00000087},
    '{ROW_CFG, sstwd_pkg::CMD_SHOW,   14'd0,     1'b0, 4'd15, 1'b0, 32'h0},
    '{ROW_CMD, sstwd_pkg::CMD_BRIGHT, 14'd0,     1'b0, 4'd0,  1'b1, 32'h0000008f},
    '{ROW_CFG, sstwd_pkg::CMD_SHOW,   14'd0,     1'b0, 4'd9,  1'b0, 32'h0},
    '{ROW_CMD, sstwd_pkg::CMD_BRIGHT, 14'd0,     1'b0, 4'd0,  1'b1, 32'h0000008f},
    '{ROW_CFG, sstwd_pkg::CMD_SHOW,   14'd0,     1'b0, 4'd1,  1'b0, 32'h0},
    '{ROW_CMD, sstwd_pkg::CMD_BRIGHT, 14'd0,     1'b0, 4'd0,  1'b1, 32'h00000088},
    '{ROW_CFG, sstwd_pkg::CMD_SHOW,   14'd0,     1'b0, 4'd5,  1'b0, 32'h0},
    '{ROW_CMD, sstwd_pkg::CMD_BRIGHT, 14'd0,     1'b0, 4'd0,  1'b0, 32'h0},
    '{ROW_CMD, sstwd_pkg::CMD_SHOW,   14'd4096,  1'b1, 4'd0,  1'b0, 32'h0},
    '{ROW_CFG, sstwd_pkg::CMD_SHOW,   14'd0,     1'b0, 4'd8,  1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic command = sstwd_pkg::CMD_SHOW;
  logic [13:0] value = '0;
  logic separator = 1'b0;
  logic cfg_valid = 1'b0;
  logic [3:0] cfg_data = '0;
  logic busy;
  logic cfg_ready;
  logic strobe;
  logic [1:0] symbol;
  logic bit_value;
  logic last;

  bus_symbol_t expected_symbols [$];
  bus_symbol_t want;
  logic [3:0] model_brightness = sstwd_pkg::BRIGHT_RESET;
  int error_count = 0;
  int stall_cycles = 0;
  int symbols_seen = 0;
  int show_count = 0;
  int bright_count = 0;
  int level_writes = 0;

  seven_segment_two_wire_display_sequencer dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .value(value),
    .separator(separator),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .symbol(symbol),
    .bit_value(bit_value),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Control byte for a brightness command, or the segment codes of the four low digits.
  function automatic logic [31:0] predicted_codes(logic cmd, logic [13:0] val, logic sep);
    logic [31:0] codes;
    logic [3:0] level;
    int rest;
    codes = '0;
    if (cmd == sstwd_pkg::CMD_BRIGHT) begin
      level = (model_brightness > sstwd_pkg::BRIGHT_MAX) ? sstwd_pkg::BRIGHT_MAX
                                                           : model_brightness;
      codes[7:0] = sstwd_pkg::BYTE_CTRL + {4'd0, level};
    end else begin
      rest = val;
      for (int d = 0; d < DIGITS; d++) begin
        codes[8*d +: 8] = SEGMENTS[rest % 10];
        if (d == 2 && sep) begin
          codes[8*d +: 8] = codes[8*d +: 8] | sstwd_pkg::SEG_DP;
        end
        rest = rest / 10;
      end
    end
    return codes;
  endfunction

  function automatic void queue_symbol(logic [1:0] sym, logic bit_level, logic is_last);
    expected_symbols.push_back(bus_symbol_t'{sym, bit_level, is_last});
  endfunction

  function automatic void queue_byte(logic [7:0] data);
    for (int i = 0; i < 8; i++) begin
      queue_symbol(sstwd_pkg::SYM_BIT, data[i], 1'b0);
    end
    queue_symbol(sstwd_pkg::SYM_ACK, 1'b0, 1'b0);
  endfunction

  function automatic void queue_frames(logic cmd, logic [31:0] codes);
    queue_symbol(sstwd_pkg::SYM_START, 1'b0, 1'b0);
    if (cmd == sstwd_pkg::CMD_BRIGHT) begin
      queue_byte(codes[7:0]);
    end else begin
      queue_byte(sstwd_pkg::BYTE_DATA_CMD);
      queue_symbol(sstwd_pkg::SYM_STOP, 1'b0, 1'b0);
      queue_symbol(sstwd_pkg::SYM_START, 1'b0, 1'b0);
      queue_byte(sstwd_pkg::BYTE_ADDR);
      for (int d = DIGITS - 1; d >= 0; d--) begin
        queue_byte(codes[8*d +: 8]);
      end
    end
    queue_symbol(sstwd_pkg::SYM_STOP, 1'b0, 1'b1);
  endfunction

  // Start stays high across back-to-back beats; this task only drops it when a gap is drawn.
  task automatic send_command(input logic cmd, input logic [13:0] val, input logic sep,
                              input bit known, input logic [31:0] known_codes, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    value <= val;
    separator <= sep;
    do @(posedge clk); while (busy);
    queue_frames(cmd, known ? known_codes : predicted_codes(cmd, val, sep));
    if (cmd == sstwd_pkg::CMD_BRIGHT) begin
      bright_count++;
    end else begin
      show_count++;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [3:0] level);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= level;
    do @(posedge clk); while (!cfg_ready);
    model_brightness = level;
    cfg_valid <= 1'b0;
    level_writes++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        symbols_seen++;
        if (expected_symbols.size() == 0) begin
          $error("unexpected symbol %0d with bit_value %0d and last %0d",
                 symbol, bit_value, last);
          error_count++;
        end else begin
          want = expected_symbols.pop_front();
          if (symbol !== want.sym) begin
            $error("symbol: expected %0d, got %0d", want.sym, symbol);
            error_count++;
          end
          if (bit_value !== want.bit_value) begin
            $error("bit_value: expected %0d, got %0d", want.bit_value, bit_value);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            error_count++;
          end
        end
      end
      if (strobe || (start && !busy) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] brightness_plan [5];
    logic [3:0] level;
    logic cmd;
    logic [13:0] val;
    bit burst;
    int gap;
    brightness_plan = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd9};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        set_brightness(directed_rows[r].level);
      end else begin
        send_command(directed_rows[r].cmd, directed_rows[r].val, directed_rows[r].sep,
                     directed_rows[r].known, directed_rows[r].codes, $urandom_range(0, 5));
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      level = (p < 5) ? brightness_plan[p] : 4'($urandom_range(0, 15));
      set_brightness(level);
      // Every other phase runs mostly back to back to keep the symbol queue full.
      burst = (p % 2 == 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        cmd = ($urandom_range(0, 9) < 3) ? sstwd_pkg::CMD_BRIGHT : sstwd_pkg::CMD_SHOW;
        if ($urandom_range(0, 4) == 0) begin
          val = 14'($urandom_range(0, 16383));
        end else begin
          val = 14'($urandom_range(0, 9999));
        end
        if (burst && $urandom_range(0, 3) != 0) begin
          gap = 0;
        end else begin
          gap = $urandom_range(0, 5);
        end
        send_command(cmd, val, 1'($urandom_range(0, 1)), 1'b0, '0, gap);
      end
    end

    start <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d display and %0d brightness commands over %0d brightness settings,",
             show_count, bright_count, level_writes);
    $display("and checked %0d bus symbols.", symbols_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: seven_segment_two_wire_display_sequencer.f
hdl/sstwd_pkg.sv
hdl/sstwd_front.sv
hdl/sstwd_fifo.sv
hdl/sstwd_back.sv
hdl/seven_segment_two_wire_display_sequencer.sv
verif/seven_segment_two_wire_display_sequencer_tb.sv
